// File: src/sia_pkg.sv
// Shared constants, types, microcode and character mapping for the radix text converter.
`default_nettype none

package sia_pkg;

   localparam int VALUE_BITS = 32;
   localparam int MAX_DIGITS = 32;

   localparam int DIGIT_W = 6;
   localparam int CHAR_W  = 7;
   localparam int RADIX_W = 6;
   localparam int REM_W   = DIGIT_W + 1;
   localparam int COUNT_W = $clog2(MAX_DIGITS + 1);
   localparam int ADDR_W  = $clog2(MAX_DIGITS);

   // The divider retires this many quotient bits per cycle.
   localparam int DIV_STEP_BITS = 4;
   localparam int DIV_CYCLES    = (VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
   localparam int DIV_W         = DIV_CYCLES * DIV_STEP_BITS;
   localparam int DIV_CNT_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

   localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = 6'd10;
   localparam logic [CHAR_W-1:0]  CH_ZERO       = 7'h30;
   localparam logic [CHAR_W-1:0]  CH_NINE       = 7'h39;
   localparam logic [CHAR_W-1:0]  CH_LOWER_A    = 7'h61;
   localparam logic [CHAR_W-1:0]  CH_LOWER_Z    = 7'h7A;
   localparam logic [CHAR_W-1:0]  CH_MINUS      = 7'h2D;

   localparam int PC_W = 3;
   typedef logic [PC_W-1:0] pc_type;

   localparam pc_type PC_WAIT  = 3'd0;
   localparam pc_type PC_DIV   = 3'd1;
   localparam pc_type PC_STORE = 3'd2;
   localparam pc_type PC_SIGN  = 3'd3;
   localparam pc_type PC_READ  = 3'd4;
   localparam pc_type PC_EMIT  = 3'd5;
   localparam pc_type PC_END   = 3'd6;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_DIV_MORE,
      COND_MORE_DIGITS,
      COND_MORE_CHARS
   } cond_type;

   typedef struct packed {
      logic     req_ready;
      logic     div_step;
      logic     store_digit;
      logic     emit_sign;
      logic     rd_digit;
      logic     emit_digit;
      cond_type cond;
      pc_type   target;
   } uword_type;

   typedef struct packed {
      logic req_ready;
      logic div_step;
      logic store_digit;
      logic emit_sign;
      logic rd_digit;
      logic emit_digit;
   } ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic div_more;
      logic more_digits;
      logic negative;
      logic more_chars;
      logic out_free;
   } status_type;

   // Control store: one word per step.
   function automatic uword_type microcode(input pc_type pc);
      uword_type w;
      w = '0;
      w.cond = COND_NEVER;
      w.target = PC_WAIT;
      case (pc)
         PC_WAIT: begin
            w.req_ready = 1'b1;
            w.cond = COND_NO_REQ;
            w.target = PC_WAIT;
         end
         PC_DIV: begin
            w.div_step = 1'b1;
            w.cond = COND_DIV_MORE;
            w.target = PC_DIV;
         end
         PC_STORE: begin
            w.store_digit = 1'b1;
            w.cond = COND_MORE_DIGITS;
            w.target = PC_DIV;
         end
         PC_SIGN: begin
            w.emit_sign = 1'b1;
         end
         PC_READ: begin
            w.rd_digit = 1'b1;
         end
         PC_EMIT: begin
            w.emit_digit = 1'b1;
            w.cond = COND_MORE_CHARS;
            w.target = PC_READ;
         end
         PC_END: begin
            w.cond = COND_ALWAYS;
            w.target = PC_WAIT;
         end
         default: begin
            w.cond = COND_ALWAYS;
            w.target = PC_WAIT;
         end
      endcase
      return w;
   endfunction

   function automatic logic [CHAR_W-1:0] char_of_digit(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d < DECIMAL_LIMIT) begin
         c = CH_ZERO + {1'b0, d};
      end else begin
         c = CH_LOWER_A + {1'b0, d} - {1'b0, DECIMAL_LIMIT};
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: src/sia_if.sv
// Valid/ready channel interfaces for the request and response sides.
`default_nettype none

interface sia_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [sia_pkg::VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface sia_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sia_pkg::CHAR_W-1:0]    char_code;
   logic                          last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

// File: src/sia_sequencer.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`default_nettype none

module sia_sequencer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sia_pkg::status_type status,
   output sia_pkg::ctrl_type        ctrl
);

   sia_pkg::pc_type    pc_ff;
   sia_pkg::pc_type    pc_in;
   sia_pkg::uword_type uw;
   logic               stall;
   logic               jump;

   assign uw = sia_pkg::microcode(pc_ff);

   // An output step waits while the response register still holds an untaken beat.
   assign stall = !status.out_free &&
                  (uw.emit_digit || (uw.emit_sign && status.negative));

   always_comb begin
      case (uw.cond)
         sia_pkg::COND_NEVER:       jump = 1'b0;
         sia_pkg::COND_ALWAYS:      jump = 1'b1;
         sia_pkg::COND_NO_REQ:      jump = !status.req_valid;
         sia_pkg::COND_DIV_MORE:    jump = status.div_more;
         sia_pkg::COND_MORE_DIGITS: jump = status.more_digits;
         sia_pkg::COND_MORE_CHARS:  jump = status.more_chars;
         default:                   jump = 1'b1;
      endcase
   end

   always_comb begin
      if (stall) begin
         pc_in = pc_ff;
      end else if (jump) begin
         pc_in = uw.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= sia_pkg::PC_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   always_comb begin
      ctrl.req_ready   = uw.req_ready;
      ctrl.div_step    = uw.div_step;
      ctrl.store_digit = uw.store_digit;
      ctrl.emit_sign   = uw.emit_sign && status.negative && status.out_free;
      ctrl.rd_digit    = uw.rd_digit;
      ctrl.emit_digit  = uw.emit_digit && status.out_free;
   end

endmodule

`default_nettype wire

// File: src/sia_datapath.sv
// Datapath: radix register, magnitude divider, digit store and response register.
`default_nettype none

module sia_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   sia_req_if.sink                          req_bus,
   sia_rsp_if.source                        rsp_bus,
   input  wire logic                        csr_we,
   input  wire logic [sia_pkg::RADIX_W-1:0] csr_wdata,
   input  wire sia_pkg::ctrl_type           ctrl,
   output sia_pkg::status_type              status
);

   logic [sia_pkg::RADIX_W-1:0]    radix_ff;
   logic [sia_pkg::RADIX_W-1:0]    base_ff;
   logic [sia_pkg::RADIX_W-1:0]    base_in;
   logic                           neg_ff;
   logic [sia_pkg::DIV_W-1:0]      mag_ff;
   logic [sia_pkg::DIV_W-1:0]      mag_in;
   logic [sia_pkg::DIGIT_W-1:0]    rem_ff;
   logic [sia_pkg::DIGIT_W-1:0]    rem_in;
   logic [sia_pkg::DIV_CNT_W-1:0]  div_cnt_ff;
   logic [sia_pkg::COUNT_W-1:0]    count_ff;
   logic [sia_pkg::COUNT_W-1:0]    count_dec;
   logic [sia_pkg::DIGIT_W-1:0]    digit_store [sia_pkg::MAX_DIGITS];
   logic [sia_pkg::DIGIT_W-1:0]    rd_digit_ff;
   logic                           rsp_valid_ff;
   logic [sia_pkg::CHAR_W-1:0]     rsp_char_ff;
   logic                           rsp_last_ff;
   logic [sia_pkg::VALUE_BITS-1:0] abs_value;
   logic                           load;
   logic                           out_free;
   logic                           div_last;

   assign load      = ctrl.req_ready && req_bus.valid;
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign count_dec = count_ff - 1'b1;
   assign div_last  = div_cnt_ff == sia_pkg::DIV_CNT_W'(sia_pkg::DIV_CYCLES - 1);

   // Unsigned magnitude; the most negative value maps onto itself, which is exact.
   assign abs_value = req_bus.value[sia_pkg::VALUE_BITS-1] ?
                      (~$unsigned(req_bus.value) + 1'b1) : $unsigned(req_bus.value);

   always_comb begin
      if (radix_ff < sia_pkg::RADIX_MIN) begin
         base_in = sia_pkg::RADIX_MIN;
      end else if (radix_ff > sia_pkg::RADIX_MAX) begin
         base_in = sia_pkg::RADIX_MAX;
      end else begin
         base_in = radix_ff;
      end
   end

   // Restoring division, several quotient bits per cycle. The quotient shifts in
   // behind the dividend, so after the last cycle the register holds the quotient.
   always_comb begin
      logic [sia_pkg::REM_W-1:0] trial;
      rem_in = rem_ff;
      mag_in = mag_ff;
      for (int i = 0; i < sia_pkg::DIV_STEP_BITS; i++) begin
         trial  = {rem_in, mag_in[sia_pkg::DIV_W-1]};
         mag_in = {mag_in[sia_pkg::DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, base_ff}) begin
            trial     = trial - {1'b0, base_ff};
            mag_in[0] = 1'b1;
         end
         rem_in = trial[sia_pkg::DIGIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff     <= sia_pkg::RADIX_RESET;
         neg_ff       <= 1'b0;
         mag_ff       <= '0;
         rem_ff       <= '0;
         div_cnt_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            radix_ff <= csr_wdata;
         end
         if (load) begin
            neg_ff     <= req_bus.value[sia_pkg::VALUE_BITS-1];
            mag_ff     <= sia_pkg::DIV_W'(abs_value);
            rem_ff     <= '0;
            div_cnt_ff <= '0;
            count_ff   <= '0;
         end
         if (ctrl.div_step) begin
            mag_ff     <= mag_in;
            rem_ff     <= rem_in;
            div_cnt_ff <= div_last ? '0 : div_cnt_ff + 1'b1;
         end
         if (ctrl.store_digit) begin
            count_ff <= count_ff + 1'b1;
            rem_ff   <= '0;
         end
         if (ctrl.rd_digit) begin
            count_ff <= count_dec;
         end
         if (ctrl.emit_sign || ctrl.emit_digit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         base_ff <= base_in;
      end
      if (ctrl.store_digit) begin
         digit_store[count_ff[sia_pkg::ADDR_W-1:0]] <= rem_ff;
      end
      if (ctrl.rd_digit) begin
         rd_digit_ff <= digit_store[count_dec[sia_pkg::ADDR_W-1:0]];
      end
      if (ctrl.emit_sign) begin
         rsp_char_ff <= sia_pkg::CH_MINUS;
         rsp_last_ff <= 1'b0;
      end else if (ctrl.emit_digit) begin
         rsp_char_ff <= sia_pkg::char_of_digit(rd_digit_ff);
         rsp_last_ff <= count_ff == '0;
      end
   end

   assign req_bus.ready     = ctrl.req_ready;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.char_code = rsp_char_ff;
   assign rsp_bus.last_char = rsp_last_ff;

   always_comb begin
      status.req_valid   = req_bus.valid;
      status.div_more    = !div_last;
      status.more_digits = (mag_ff != '0) &&
                           (count_ff < sia_pkg::COUNT_W'(sia_pkg::MAX_DIGITS - 1));
      status.negative    = neg_ff;
      status.more_chars  = count_ff != '0;
      status.out_free    = out_free;
   end

endmodule

`default_nettype wire

// File: src/signed_integer_to_radix_ascii.sv
// Top level: signed integer to ASCII text in a configurable base.
//
//   channel   direction  payload                 beat means
//   req_bus   in         value (32b signed)      one integer to convert
//   rsp_bus   out        char_code, last_char    one character, most significant first
//   csr_      in         csr_wdata (6b radix)    write of the radix register
//
// Each digit takes a run of divider steps at 4 quotient bits each, plus a store step.
// Each character then takes a store read and an emit step, and the sign, the start and
// the finish have their own steps. There is one divider, shared by all the digits.
// Reset is synchronous and returns the radix to ten. A stalled response beat holds the
// sequencer at its output step; one integer is converted at a time.
`default_nettype none

module signed_integer_to_radix_ascii (
   input  wire logic                        clock,
   input  wire logic                        reset,
   sia_req_if.sink                          req_bus,
   sia_rsp_if.source                        rsp_bus,
   input  wire logic                        csr_we,
   input  wire logic [sia_pkg::RADIX_W-1:0] csr_wdata
);

   sia_pkg::ctrl_type   ctrl;
   sia_pkg::status_type status;

   sia_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   sia_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .ctrl      (ctrl),
      .status    (status)
   );

`ifndef NO_ASSERTIONS
   // Only one integer is in conversion at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready)
      else $error("request taken while a conversion is still running");

   // Every character is a minus sign, a decimal digit or a lower-case letter.
   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |->
         (rsp_bus.char_code == sia_pkg::CH_MINUS) ||
         (rsp_bus.char_code >= sia_pkg::CH_ZERO && rsp_bus.char_code <= sia_pkg::CH_NINE) ||
         (rsp_bus.char_code >= sia_pkg::CH_LOWER_A &&
          rsp_bus.char_code <= sia_pkg::CH_LOWER_Z))
      else $error("response character outside the digit alphabet");

   // A response beat that is not taken stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=>
         rsp_bus.valid && $stable(rsp_bus.char_code) && $stable(rsp_bus.last_char))
      else $error("response beat changed while stalled");
`endif

endmodule

`default_nettype wire
